// ----- rtl/utf8_to_utf16_transcoder_macros.svh -----
// Assertion macros shared by the UTF-8 to UTF-16 transcoder modules.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

`ifndef SYNTHESIS
`define U8U16_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("u8u16 assertion failed");
`define U8U16_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("u8u16 forbidden condition seen");
`else
`define U8U16_ASSERT(label, clk, rst, prop)
`define U8U16_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- rtl/u8u16_pkg.sv -----
// Types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

   localparam int POINT_W     = 21;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QUEUE_AW + 1;

   localparam logic [15:0]        REPLACEMENT = 16'hFFFD;
   localparam logic [POINT_W-1:0] SURR_LO     = 21'h00D800;
   localparam logic [POINT_W-1:0] SURR_HI     = 21'h00DFFF;
   localparam logic [POINT_W-1:0] MAX_POINT   = 21'h10FFFF;
   localparam logic [POINT_W-1:0] BMP_MAX     = 21'h00FFFF;
   localparam logic [POINT_W-1:0] PLANE_BASE  = 21'h010000;
   localparam logic [POINT_W-1:0] MIN_LEN2    = 21'h000080;
   localparam logic [POINT_W-1:0] MIN_LEN3    = 21'h000800;
   localparam logic [5:0]         HI_PREFIX   = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]         LO_PREFIX   = 6'b110111;  // 0xDC00 >> 10

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_end;
      logic        stream_end;
   } unit_type;

   // One decoded byte: zero, one or two code units.
   typedef struct packed {
      logic     any;
      logic     pair;
      unit_type unit0;
      unit_type unit1;
   } dec_type;

   typedef struct packed {
      logic     pair;
      unit_type unit0;
      unit_type unit1;
   } entry_type;

endpackage

// ----- rtl/u8u16_decoder.sv -----
// Sequence state and combinational byte decode into UTF-16 code units.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_decoder import u8u16_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   input  logic       last_byte,
   output dec_type    dec
);

   logic [2:0]         exp_len_ff, exp_len_in;
   logic [1:0]         seen_ff, seen_in;
   logic [POINT_W-1:0] point_ff, point_in;

   logic               lead_opens;
   logic [2:0]         lead_len;
   logic [POINT_W-1:0] lead_payload;
   logic [15:0]        lead_unit;
   logic [15:0]        lead_out;

   logic               cont;
   logic [2:0]         seen_next;
   logic [POINT_W-1:0] acc;
   logic [POINT_W-1:0] offs;
   logic               complete;
   logic               bad;
   logic               supp;

   logic [15:0]        u0, u1;
   logic [1:0]         n;

   always_comb begin
      lead_opens   = 1'b0;
      lead_len     = LEN_NONE;
      lead_payload = '0;
      lead_unit    = REPLACEMENT;
      case (byte_in) inside
         [8'h00:8'h7F]: begin
            lead_unit = {8'h00, byte_in};
         end
         [8'hC0:8'hDF]: begin
            lead_opens   = 1'b1;
            lead_len     = LEN_TWO;
            lead_payload = {16'h0000, byte_in[4:0]};
         end
         [8'hE0:8'hEF]: begin
            lead_opens   = 1'b1;
            lead_len     = LEN_THREE;
            lead_payload = {17'h00000, byte_in[3:0]};
         end
         [8'hF0:8'hF7]: begin
            lead_opens   = 1'b1;
            lead_len     = LEN_FOUR;
            lead_payload = {18'h00000, byte_in[2:0]};
         end
         default: begin
            lead_unit = REPLACEMENT;
         end
      endcase
   end

   // An opening lead on the final byte can never finish.
   assign lead_out = lead_opens ? REPLACEMENT : lead_unit;

   assign cont      = (byte_in[7:6] == 2'b10);
   assign seen_next = {1'b0, seen_ff} + 3'd1;
   assign acc       = {point_ff[POINT_W-7:0], byte_in[5:0]};
   assign complete  = (seen_next >= exp_len_ff);
   assign offs      = acc - PLANE_BASE;
   assign supp      = (acc > BMP_MAX);
   assign bad       = (acc >= SURR_LO && acc <= SURR_HI) || (acc > MAX_POINT) ||
                      (exp_len_ff == LEN_TWO   && acc < MIN_LEN2) ||
                      (exp_len_ff == LEN_THREE && acc < MIN_LEN3) ||
                      (exp_len_ff == LEN_FOUR  && acc < PLANE_BASE);

   always_comb begin
      u0         = REPLACEMENT;
      u1         = REPLACEMENT;
      n          = 2'd0;
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      point_in   = point_ff;
      if (exp_len_ff == LEN_NONE || !cont) begin
         // No open sequence, or an interrupted one: flag an interruption, then treat the byte as a lead.
         if (exp_len_ff != LEN_NONE) begin
            u0 = REPLACEMENT;
            n  = 2'd1;
         end
         exp_len_in = LEN_NONE;
         seen_in    = 2'd0;
         point_in   = '0;
         if (lead_opens && !last_byte) begin
            exp_len_in = lead_len;
            seen_in    = 2'd1;
            point_in   = lead_payload;
         end else begin
            if (n == 2'd0) begin
               u0 = lead_out;
            end else begin
               u1 = lead_out;
            end
            n = n + 2'd1;
         end
      end else if (complete) begin
         exp_len_in = LEN_NONE;
         seen_in    = 2'd0;
         point_in   = '0;
         if (bad) begin
            u0 = REPLACEMENT;
            n  = 2'd1;
         end else if (!supp) begin
            u0 = acc[15:0];
            n  = 2'd1;
         end else begin
            u0 = {HI_PREFIX, offs[19:10]};
            u1 = {LO_PREFIX, offs[9:0]};
            n  = 2'd2;
         end
      end else if (last_byte) begin
         u0         = REPLACEMENT;
         n          = 2'd1;
         exp_len_in = LEN_NONE;
         seen_in    = 2'd0;
         point_in   = '0;
      end else begin
         seen_in  = seen_next[1:0];
         point_in = acc;
      end
   end

   always_comb begin
      dec.any              = (n != 2'd0);
      dec.pair             = (n == 2'd2);
      dec.unit0.code_unit  = u0;
      dec.unit0.run_end    = (n == 2'd1);
      dec.unit0.stream_end = (n == 2'd1) && last_byte;
      dec.unit1.code_unit  = u1;
      dec.unit1.run_end    = 1'b1;
      dec.unit1.stream_end = last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= LEN_NONE;
         seen_ff    <= 2'd0;
         point_ff   <= '0;
      end else if (step) begin
         exp_len_ff <= exp_len_in;
         seen_ff    <= seen_in;
         point_ff   <= point_in;
      end
   end

   `U8U16_ASSERT(a_idle_clean, clock, reset, (exp_len_ff == LEN_NONE) |-> (seen_ff == 2'd0 && point_ff == '0))
   `U8U16_ASSERT(a_open_sane, clock, reset, (exp_len_ff != LEN_NONE) |-> (exp_len_ff >= LEN_TWO && exp_len_ff <= LEN_FOUR && seen_ff != 2'd0 && {1'b0, seen_ff} < exp_len_ff))
   `U8U16_ASSERT(a_pair_tags, clock, reset, dec.pair |-> (dec.any && dec.unit1.run_end && !dec.unit0.run_end))

endmodule

// ----- rtl/u8u16_out_queue.sv -----
// Result queue: holds decoded bytes and hands out one code unit per beat.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_out_queue import u8u16_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type entry_in,
   output logic      full,
   output logic      out_valid,
   input  logic      out_ready,
   output unit_type  out_unit
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                half_ff, half_in;

   entry_type           head;
   logic                pop_beat;
   logic                advance;

   assign head      = entries_ff[rd_ptr_ff];
   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_unit  = half_ff ? head.unit1 : head.unit0;
   assign pop_beat  = out_valid && out_ready;
   // Drop the head entry after its last unit has gone out.
   assign advance   = pop_beat && (!head.pair || half_ff);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = advance ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, advance};
      half_in   = half_ff;
      if (pop_beat) begin
         half_in = head.pair && !half_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         half_ff   <= half_in;
      end
   end

   `U8U16_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= QCNT_W'(QUEUE_DEPTH))
   `U8U16_ASSERT(a_half_on_pair, clock, reset, half_ff |-> (out_valid && head.pair))
   `U8U16_NEVER(a_no_push_full, clock, reset, push && full)

endmodule

// ----- rtl/utf8_to_utf16_transcoder.sv -----
// A byte is held in the input register, then its code units go into the result queue.
// Throughput: one byte per cycle while the queue has room and each byte yields at most one
// code unit; a two-unit byte takes two result beats, set by the one-unit result port.
// A four-entry result queue absorbs stalls on the result side.
// Reset (synchronous, active high) closes any open sequence and empties the queue.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tuser,   // [0] run_end
   output logic        rsp_tlast    // stream_end
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic       full;
   logic       fire;
   dec_type    dec;
   entry_type  entry;
   unit_type   out_unit;

   // Decode the held byte once the queue has a free entry.
   assign fire        = in_valid_ff && !full;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   u8u16_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .byte_in   (in_byte_ff),
      .last_byte (in_last_ff),
      .dec       (dec)
   );

   assign entry.pair  = dec.pair;
   assign entry.unit0 = dec.unit0;
   assign entry.unit1 = dec.unit1;

   u8u16_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && dec.any),
      .entry_in  (entry),
      .full      (full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_unit  (out_unit)
   );

   assign rsp_tdata = out_unit.code_unit;
   assign rsp_tuser = out_unit.run_end;
   assign rsp_tlast = out_unit.stream_end;

endmodule

// ----- tb/utf8_to_utf16_transcoder_tb.sv -----
// Self-checking stream testbench for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb;
   import u8u16_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_BYTES = 1800;
   localparam int TAIL_CYCLES  = 16;
   localparam int DIRECTED_N   = 25;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;     // 1: expected units given below, 0: from the decoder model
      logic [1:0]  n_units;
      logic [15:0] cu0;
      logic [15:0] cu1;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] byte_in
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] code_unit
   logic        rsp_tuser;          // [0] run_end
   logic        rsp_tlast;          // stream_end

   // decoder model state
   logic [2:0]  open_len = LEN_NONE;
   logic [2:0]  seen_bytes = 3'd0;
   logic [20:0] partial_point = '0;

   unit_type    byte_units[$];
   unit_type    expected_units[$];
   unit_type    monitor_want;
   row_type     directed_rows [0:DIRECTED_N-1];

   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   int          sent_bytes = 0;
   logic        src_calm = 1'b0;
   logic        snk_calm = 1'b0;

   utf8_to_utf16_transcoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic push_unit(input logic [15:0] cu);
      unit_type u;
      u.code_unit  = cu;
      u.run_end    = 1'b0;
      u.stream_end = 1'b0;
      byte_units.push_back(u);
   endtask

   task automatic close_sequence();
      open_len      = LEN_NONE;
      seen_bytes    = 3'd0;
      partial_point = '0;
   endtask

   task automatic take_lead(input logic [7:0] b, input logic last);
      if (!b[7]) begin
         push_unit({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
         open_len      = LEN_TWO;
         seen_bytes    = 3'd1;
         partial_point = {16'h0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         open_len      = LEN_THREE;
         seen_bytes    = 3'd1;
         partial_point = {17'h0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         open_len      = LEN_FOUR;
         seen_bytes    = 3'd1;
         partial_point = {18'h0, b[2:0]};
      end else begin
         push_unit(REPLACEMENT);
      end
      // flush a sequence opened by the final byte
      if (last && open_len != LEN_NONE) begin
         push_unit(REPLACEMENT);
         close_sequence();
      end
   endtask

   task automatic finish_point();
      logic [20:0] cp;
      logic [20:0] v;
      logic [2:0]  shortest;
      cp = partial_point;
      if (cp < MIN_LEN2)
         shortest = 3'd1;
      else if (cp < MIN_LEN3)
         shortest = LEN_TWO;
      else if (cp <= BMP_MAX)
         shortest = LEN_THREE;
      else
         shortest = LEN_FOUR;
      if ((cp >= SURR_LO && cp <= SURR_HI) || cp > MAX_POINT || shortest != open_len) begin
         push_unit(REPLACEMENT);
      end else if (cp <= BMP_MAX) begin
         push_unit(cp[15:0]);
      end else begin
         v = cp - PLANE_BASE;
         push_unit({HI_PREFIX, v[19:10]});
         push_unit({LO_PREFIX, v[9:0]});
      end
   endtask

   // Leave the code units of one byte in byte_units, flags set.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      unit_type u;
      byte_units = {};
      if (open_len == LEN_NONE) begin
         take_lead(b, last);
      end else if (b[7:6] != 2'b10) begin
         push_unit(REPLACEMENT);
         close_sequence();
         take_lead(b, last);
      end else begin
         partial_point = {partial_point[14:0], b[5:0]};
         seen_bytes    = seen_bytes + 3'd1;
         if (seen_bytes >= open_len) begin
            finish_point();
            close_sequence();
         end else if (last) begin
            push_unit(REPLACEMENT);
            close_sequence();
         end
      end
      if (byte_units.size() > 0) begin
         u = byte_units.pop_back();
         u.run_end    = 1'b1;
         u.stream_end = last;
         byte_units.push_back(u);
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                            input logic [1:0] n_units, input logic [15:0] cu0,
                            input logic [15:0] cu1);
      int       gap;
      unit_type u;
      if ($urandom_range(0, 199) == 0)
         src_calm = !src_calm;
      gap = (src_calm || $urandom_range(0, 99) < 55) ? 0 : gap_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_byte(data, last);
      if (!typed) begin
         foreach (byte_units[i])
            expected_units.push_back(byte_units[i]);
      end else begin
         for (int i = 0; i < n_units; i++) begin
            u.code_unit  = (i == 0) ? cu0 : cu1;
            u.run_end    = (i == n_units - 1);
            u.stream_end = u.run_end & last;
            expected_units.push_back(u);
         end
      end
   endtask

   // One random character: well-formed mostly, else malformed, cut short or a stray byte.
   task automatic send_char();
      logic [7:0]  seq [4];
      logic [20:0] cp;
      logic [20:0] lo;
      logic [20:0] hi;
      logic        last;
      int          kind;
      int          len;
      int          send_n;
      int          pick;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      case (len)
         1: begin lo = 21'h0;     hi = 21'h7F;     end
         2: begin lo = MIN_LEN2;  hi = 21'h7FF;    end
         3: begin lo = MIN_LEN3;  hi = BMP_MAX;    end
         default: begin lo = PLANE_BASE; hi = MAX_POINT; end
      endcase
      pick = $urandom_range(0, 15);
      cp = (pick == 0) ? lo : (pick == 1) ? hi : 21'($urandom_range(lo, hi));
      if (cp >= SURR_LO && cp <= SURR_HI)
         cp = cp | 21'h2000;
      if (kind >= 70 && kind < 82) begin
         // arbitrary payload: overlong, surrogate and out-of-range forms
         len = $urandom_range(2, 4);
         cp  = 21'($urandom) & ((21'd1 << (5 * len + 1)) - 21'd1);
      end
      case (len)
         1: seq[0] = cp[7:0];
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      send_n = len;
      if (kind >= 82 && kind < 92 && len > 1)
         send_n = $urandom_range(1, len - 1);
      if (kind >= 92) begin
         seq[0] = 8'($urandom_range(0, 255));
         send_n = 1;
      end
      for (int i = 0; i < send_n; i++) begin
         last = ($urandom_range(0, 99) < 2) || (i == send_n - 1 && $urandom_range(0, 29) == 0);
         send_byte(seq[i], last, 1'b0, 2'd0, 16'h0000, 16'h0000);
         sent_bytes++;
      end
   endtask

   // result side: random stalls, with calm stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 299) == 0)
            snk_calm <= !snk_calm;
         if (!snk_calm && $urandom_range(0, 99) < 20)
            stall_left <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_units.size() == 0) begin
            $display("%0t: unexpected beat: code_unit %h run_end %b stream_end %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            monitor_want = expected_units.pop_front();
            if (rsp_tdata !== monitor_want.code_unit || rsp_tuser !== monitor_want.run_end ||
                rsp_tlast !== monitor_want.stream_end) begin
               $display("%0t: expected code_unit %h run_end %b stream_end %b, got %h %b %b",
                        $time, monitor_want.code_unit, monitor_want.run_end,
                        monitor_want.stream_end, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: abort when no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic paused;
      paused = 1'b0;
      directed_rows = '{
         '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},
         '{8'h7F, 1'b1, 1'b1, 2'd1, 16'h007F, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // stray continuation
         '{8'hFF, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // invalid lead
         '{8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hC0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // overlong
         '{8'hED, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hA0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // encoded surrogate
         '{8'hF4, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'h8F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hF4, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h90, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // above U+10FFFF
         '{8'hE2, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h41, 1'b0, 1'b1, 2'd2, REPLACEMENT, 16'h0041},  // interrupted
         '{8'hC3, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hF0, 1'b1, 1'b1, 2'd2, REPLACEMENT, REPLACEMENT},
         '{8'hE2, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h82, 1'b1, 1'b1, 2'd1, REPLACEMENT, 16'h0000}   // unfinished at stream end
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].n_units, directed_rows[i].cu0, directed_rows[i].cu1);

      while (sent_bytes < RANDOM_BYTES) begin
         // hold the sender once until the result side has drained
         if (!paused && sent_bytes >= RANDOM_BYTES / 2) begin
            paused = 1'b1;
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait (expected_units.size() == 0);
         end
         send_char();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_units.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_units.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_decoder.sv
rtl/u8u16_out_queue.sv
rtl/utf8_to_utf16_transcoder.sv
tb/utf8_to_utf16_transcoder_tb.sv
